FILE: rtl/core/sit_pkg.sv
// Package for the sorted insert table: control types shared by the
// sequencer in the top level and the storage cells. No dependencies.

package sit_pkg;

  // Width of one stored entry and of the position field.
  localparam int unsigned ENTRY_W = 32;
  localparam int unsigned POS_W   = 4;

  // Control handed from the sequencer to every cell of the row.
  typedef struct packed {
    logic insert;   // Take the new value or the left neighbor's entry where needed.
    logic rotate;   // Take the right neighbor's entry (listing rotation).
  } cell_ctrl_t;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_t;

endpackage

FILE: rtl/core/sorted_insert_table_top.sv
// Top level of the sorted insert table: sequencer, output register and the
// row of sit_cell storage cells. Depends on sit_pkg and sit_cell.
//
//   Channel  Direction  Signals                      Carries
//   s        in         s_tvalid s_tready s_tdata    value to insert
//   m        out        m_tvalid m_tready m_tdata    entry and position of one place
//                       m_tlast m_tuser              last of listing, refused flag
//
// An input is inserted, or refused when the table is full; then the cell row
// rotates through all TABLE_DEPTH places to list the table from cell 0 and
// return to its original order.
// A stalled output holds the rotation while a listed entry waits; the next
// input is taken once the rotation is done, even if the last entry waits.
// Reset empties the table at once; entry storage itself is not cleared.

module sorted_insert_table_top import sit_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  // value [31:0]
  input  logic [ENTRY_W-1:0]       s_tdata,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // entry [31:0], position [35:32], zero fill [39:36]
  output logic [39:0]              m_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic                     m_tlast,
  // refused [0]
  output logic [0:0]               m_tuser
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;

  state_t             state;
  state_t             state_next;
  logic [CW-1:0]      fill;
  logic [CW-1:0]      cnt;
  logic               refused;
  logic               in_fire;
  logic               full;
  logic               emit;
  logic               step;
  logic               out_free;
  logic [XW-1:0]      cnt_x;
  cell_ctrl_t         ctrl;

  logic [ENTRY_W-1:0] cell_entry [TABLE_DEPTH];
  logic               cell_geq   [TABLE_DEPTH];

  logic [ENTRY_W-1:0] out_entry;
  logic [POS_W-1:0]   out_pos;

  // Handshake and sequencing conditions.
  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign full     = (fill == CW'(TABLE_DEPTH));
  assign out_free = !m_tvalid || m_tready;
  assign emit     = (state == ST_LIST) && (cnt < fill);
  assign step     = (state == ST_LIST) && (!emit || out_free);
  assign cnt_x    = XW'(cnt);

  assign ctrl.insert = in_fire && !full;
  assign ctrl.rotate = step;

  // Row of cells; on insert, cells at or above the insertion point shift up from
  // their left neighbor, and on rotation each takes its right neighbor's entry.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [ENTRY_W-1:0] left_entry;
    logic               left_geq;
    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_geq   = 1'b0;
    end else begin : g_rest
      assign left_entry = cell_entry[i-1];
      assign left_geq   = cell_geq[i-1];
    end
    sit_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .value       (s_tdata),
      .occupied    (CW'(i) < fill),
      .left_entry  (left_entry),
      .left_geq    (left_geq),
      .right_entry (cell_entry[(i + 1) % TABLE_DEPTH]),
      .entry       (cell_entry[i]),
      .geq         (cell_geq[i])
    );
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: list after every input, back to idle after a full rotation.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_LIST;
        end
      end
      ST_LIST: begin
        if (step && (cnt == CW'(TABLE_DEPTH - 1))) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Fill count and rotation counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      cnt  <= '0;
    end else begin
      if (ctrl.insert) begin
        fill <= fill + CW'(1);
      end
      if (in_fire) begin
        cnt <= '0;
      end else if (step) begin
        cnt <= cnt + CW'(1);
      end
    end
  end

  // Refused flag for the current listing.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      refused <= full;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload, loaded from cell 0 as the row rotates.
  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_entry  <= cell_entry[0];
      out_pos    <= cnt_x[POS_W-1:0];
      m_tlast    <= ((cnt + CW'(1)) == fill);
      m_tuser[0] <= refused;
    end
  end

  assign m_tdata = {4'b0000, out_pos, out_entry};

endmodule

FILE: rtl/core/sit_cell.sv
// One storage cell of the sorted table row. Depends on sit_pkg for the
// control struct and the entry width.

module sit_cell import sit_pkg::*; (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic [ENTRY_W-1:0] value,
  input  logic               occupied,
  input  logic [ENTRY_W-1:0] left_entry,
  input  logic               left_geq,
  input  logic [ENTRY_W-1:0] right_entry,
  output logic [ENTRY_W-1:0] entry,
  output logic               geq
);

  // An empty place counts as larger than any value, so the first empty
  // place receives the value when it belongs at the end.
  assign geq = !occupied || ($signed(entry) >= $signed(value));

  // On insert, places at or above the insertion point shift up by one;
  // the insertion point itself is the first place whose left neighbor is below.
  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (geq) begin
        entry <= left_geq ? left_entry : value;
      end
    end else if (ctrl.rotate) begin
      entry <= right_entry;
    end
  end

endmodule

FILE: bench/sorted_insert_table_top_tb.sv
// Testbench for sorted_insert_table_top: sends values to insert and checks each listed entry
// against a local model of the sorted table. Depends on sit_pkg and the RTL under rtl/core.

module sorted_insert_table_top_tb;
  import sit_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 16;
  localparam logic signed [ENTRY_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [ENTRY_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  // One listed entry as the block should emit it.
  typedef struct {
    logic signed [ENTRY_W-1:0] entry;
    logic [POS_W-1:0]          position;
    logic                      last;
    logic                      refused;
  } listed_entry_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic [ENTRY_W-1:0]  s_tdata = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [39:0]         m_tdata;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic                m_tlast;
  logic [0:0]          m_tuser;

  // Local copy of the sorted table.
  logic signed [ENTRY_W-1:0] sorted_vals [DEPTH];
  int unsigned               stored = 0;
  listed_entry_t             expected_listing [$];

  int unsigned in_gap_max = 10;
  int unsigned out_stall_max = 10;
  int unsigned out_stall_left = 0;
  int unsigned mismatches = 0;
  int unsigned inserts_sent = 0;
  int unsigned refusals_sent = 0;
  int unsigned entries_checked = 0;

  sorted_insert_table_top #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  // Apply one insert to the local table and queue the listing it causes.
  task automatic insert_and_list(input logic signed [ENTRY_W-1:0] v);
    int unsigned   place;
    int unsigned   k;
    logic          full;
    listed_entry_t row;
    full = (stored == DEPTH);
    if (full) begin
      refusals_sent++;
    end else begin
      place = stored;
      for (k = 0; k < stored; k++) begin
        if (sorted_vals[k] >= v) begin
          place = k;
          break;
        end
      end
      for (k = stored; k > place; k--) begin
        sorted_vals[k] = sorted_vals[k-1];
      end
      sorted_vals[place] = v;
      stored++;
    end
    for (k = 0; k < stored; k++) begin
      row.entry    = sorted_vals[k];
      row.position = POS_W'(k);
      row.last     = (k == stored - 1);
      row.refused  = full;
      expected_listing.push_back(row);
    end
  endtask

  // Send one value after a random gap and predict its listing on the transfer.
  task automatic send_value(input logic signed [ENTRY_W-1:0] v);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    insert_and_list(v);
    inserts_sent++;
  endtask

  // Hold off the sender until every queued entry has been listed.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_listing.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Random value: raw bits, extremes, small numbers or copies of stored entries.
  function automatic logic signed [ENTRY_W-1:0] pick_value();
    logic signed [ENTRY_W-1:0] v;
    case ($urandom_range(0, 4))
      0: v = VAL_MIN + $urandom_range(0, 3);
      1: v = VAL_MAX - $urandom_range(0, 3);
      2: v = $signed($urandom_range(0, 40)) - 20;
      3: v = (stored > 0) ? sorted_vals[$urandom_range(0, stored - 1)] : $urandom;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Receiver: compare each result transfer with the oldest expectation, then stall at random.
  always @(posedge clk) begin
    listed_entry_t exp_row;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_listing.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result entry=%0d position=%0d last=%0b refused=%0b",
                   $signed(m_tdata[31:0]), m_tdata[35:32], m_tlast, m_tuser[0]);
      end else begin
        exp_row = expected_listing.pop_front();
        entries_checked++;
        if (m_tdata[31:0] !== exp_row.entry || m_tdata[35:32] !== exp_row.position ||
            m_tlast !== exp_row.last || m_tuser[0] !== exp_row.refused) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: expected entry=%0d position=%0d last=%0b refused=%0b",
                     exp_row.entry, exp_row.position, exp_row.last, exp_row.refused);
            $display("       got      entry=%0d position=%0d last=%0b refused=%0b",
                     $signed(m_tdata[31:0]), m_tdata[35:32], m_tlast, m_tuser[0]);
          end
        end
      end
      out_stall_left = $urandom_range(0, out_stall_max);
    end else if (out_stall_left > 0) begin
      out_stall_left--;
    end
    m_tready <= !rst && (out_stall_left == 0);
  end

  // The first value goes into an empty table and lists a single entry.
  task automatic test_first_insert();
    send_value(0);
  endtask

  // Extremes, duplicates and inserts at the front, the end and the middle.
  task automatic test_ordering_extremes();
    send_value(VAL_MIN);
    send_value(VAL_MAX);
    send_value(-1);
    send_value(1);
    send_value(0);
    send_value(VAL_MIN);
    send_value(VAL_MAX);
    send_value(32'sh5555_5555);
    send_value(32'shAAAA_AAAA);
  endtask

  // Random values fill the remaining places without any idling.
  task automatic test_random_fill();
    in_gap_max = 0;
    out_stall_max = 0;
    while (stored < DEPTH) send_value(pick_value());
    in_gap_max = 10;
    out_stall_max = 10;
  endtask

  // A full table refuses every value and lists itself unchanged.
  task automatic test_full_table();
    send_value(VAL_MIN);
    send_value(VAL_MAX);
    send_value(0);
    send_value(sorted_vals[DEPTH/2]);
  endtask

  // Long random run in segments that alternate between idling and full rate.
  task automatic test_random_traffic(input int unsigned count);
    int unsigned i;
    for (i = 0; i < count; i++) begin
      if (i % 60 == 0) begin
        if ((i / 60) % 2 == 0) begin
          in_gap_max = 10;
          out_stall_max = 10;
        end else begin
          in_gap_max = 0;
          out_stall_max = 0;
        end
      end
      send_value(pick_value());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_first_insert();
    test_ordering_extremes();
    wait_drained();
    test_random_fill();
    test_full_table();
    wait_drained();
    test_random_traffic(470);
    wait_drained();
    repeat (4 * (DEPTH + 1)) @(posedge clk);
    $display("Sent %0d values (%0d refused by a full table), checked %0d listed entries.",
             inserts_sent, refusals_sent, entries_checked);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("Timeout with %0d entries still expected", expected_listing.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
